// ----- design/dsic_pkg.sv -----
// shared types and constants of the self-interference canceller
package dsic_pkg;

    localparam int HALF_SPAN    = 3;
    localparam int SAMPLE_WIDTH = 16;
    localparam int SPAN         = 2 * HALF_SPAN;
    localparam int TAP_USED     = SPAN + 1;
    localparam int TAP_COUNT    = 7;
    localparam int TAP_WIDTH    = 16;
    localparam int TAP_FRAC     = 12;
    localparam int CFG_IDX_W    = $clog2(TAP_COUNT);
    localparam int FILL_W       = $clog2(SPAN + 1);
    localparam int PROD_W       = SAMPLE_WIDTH + TAP_WIDTH;
    localparam int ACC_W        = PROD_W + $clog2(TAP_USED + 1) + 1;
    localparam int SHIFT_W      = ACC_W - TAP_FRAC;
    localparam int SAT_HEAD_W   = SHIFT_W - SAMPLE_WIDTH + 1;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [TAP_WIDTH-1:0]    tap_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [ACC_W-1:0]        acc_t;
    typedef logic signed [SHIFT_W-1:0]      shift_t;
    typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;
    typedef logic [FILL_W-1:0]              fill_t;

    typedef struct packed {
        logic    valid;
        logic    last;
        sample_t rx;
    } stage_ctl_t;

endpackage

// ----- design/dsic_tap_regs.sv -----
// channel coefficient register file written through the configuration port
module dsic_tap_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  dsic_pkg::cfg_idx_t    cfg_index,
    input  dsic_pkg::tap_t        cfg_data,
    output dsic_pkg::tap_t        taps [dsic_pkg::TAP_USED]
);

    dsic_pkg::tap_t taps_reg [dsic_pkg::TAP_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dsic_pkg::TAP_COUNT; i++) begin
                taps_reg[i] <= '0;
            end
        end else if (cfg_we && (32'(cfg_index) < dsic_pkg::TAP_COUNT)) begin
            taps_reg[cfg_index] <= cfg_data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < dsic_pkg::TAP_USED; g++) begin : g_taps
            assign taps[g] = taps_reg[g];
        end
    endgenerate

endmodule

// ----- design/dsic_history.sv -----
// transmit and receive delay lines with the window fill counter
module dsic_history (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  dsic_pkg::sample_t   tx_sample,
    input  dsic_pkg::sample_t   rx_sample,
    input  logic                last_sample,
    output dsic_pkg::sample_t   tx_win [dsic_pkg::TAP_USED],
    output dsic_pkg::sample_t   rx_old,
    output logic                full,
    output dsic_pkg::fill_t     fill_count
);

    dsic_pkg::sample_t tx_hist_reg [dsic_pkg::SPAN];
    dsic_pkg::sample_t rx_hist_reg [dsic_pkg::HALF_SPAN];
    dsic_pkg::fill_t   fill_reg;
    dsic_pkg::fill_t   fill_next;

    always_comb begin
        fill_next = fill_reg;
        if (last_sample) begin
            fill_next = '0;
        end else if (!full) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            for (int i = 0; i < dsic_pkg::SPAN; i++) begin
                tx_hist_reg[i] <= '0;
            end
            for (int i = 0; i < dsic_pkg::HALF_SPAN; i++) begin
                rx_hist_reg[i] <= '0;
            end
        end else if (accept) begin
            fill_reg <= fill_next;
            for (int i = 0; i < dsic_pkg::SPAN - 1; i++) begin
                tx_hist_reg[i] <= tx_hist_reg[i+1];
            end
            tx_hist_reg[dsic_pkg::SPAN-1] <= tx_sample;
            for (int i = 0; i < dsic_pkg::HALF_SPAN - 1; i++) begin
                rx_hist_reg[i] <= rx_hist_reg[i+1];
            end
            rx_hist_reg[dsic_pkg::HALF_SPAN-1] <= rx_sample;
        end
    end

    genvar g;
    generate
        for (g = 0; g < dsic_pkg::SPAN; g++) begin : g_win
            assign tx_win[g] = tx_hist_reg[g];
        end
    endgenerate

    assign tx_win[dsic_pkg::SPAN] = tx_sample;
    assign rx_old                 = rx_hist_reg[0];
    assign full                   = (fill_reg == dsic_pkg::fill_t'(dsic_pkg::SPAN));
    assign fill_count             = fill_reg;

endmodule

// ----- design/dsic_product_stage.sv -----
// one multiplier per tap, products registered
module dsic_product_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  dsic_pkg::stage_ctl_t ctl_in,
    input  dsic_pkg::sample_t    tx_win [dsic_pkg::TAP_USED],
    input  dsic_pkg::tap_t       taps [dsic_pkg::TAP_USED],
    output dsic_pkg::stage_ctl_t ctl_out,
    output dsic_pkg::prod_t      prods [dsic_pkg::TAP_USED]
);

    dsic_pkg::prod_t prods_reg [dsic_pkg::TAP_USED];
    logic            valid_reg;
    logic            last_reg;
    dsic_pkg::sample_t rx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            last_reg <= ctl_in.last;
            rx_reg   <= ctl_in.rx;
            for (int i = 0; i < dsic_pkg::TAP_USED; i++) begin
                prods_reg[i] <= dsic_pkg::prod_t'(taps[i] * tx_win[i]);
            end
        end
    end

    assign ctl_out.valid = valid_reg;
    assign ctl_out.last  = last_reg;
    assign ctl_out.rx    = rx_reg;

    genvar g;
    generate
        for (g = 0; g < dsic_pkg::TAP_USED; g++) begin : g_prod
            assign prods[g] = prods_reg[g];
        end
    endgenerate

endmodule

// ----- design/dsic_sum_stage.sv -----
// adder tree, floor shift and saturation into the result register
module dsic_sum_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  dsic_pkg::stage_ctl_t ctl_in,
    input  dsic_pkg::prod_t      prods [dsic_pkg::TAP_USED],
    output logic                 out_valid,
    output dsic_pkg::sample_t    residual,
    output logic                 last_out
);

    dsic_pkg::acc_t                  acc;
    dsic_pkg::shift_t                shifted;
    dsic_pkg::sample_t               sat;
    logic [dsic_pkg::SAT_HEAD_W-1:0] head;
    logic                            valid_reg;
    dsic_pkg::sample_t               residual_reg;
    logic                            last_reg;

    always_comb begin
        acc = dsic_pkg::acc_t'(ctl_in.rx) <<< dsic_pkg::TAP_FRAC;
        for (int i = 0; i < dsic_pkg::TAP_USED; i++) begin
            acc = acc - dsic_pkg::acc_t'(prods[i]);
        end
        shifted = dsic_pkg::shift_t'(acc >>> dsic_pkg::TAP_FRAC);
        head    = shifted[dsic_pkg::SHIFT_W-1:dsic_pkg::SAMPLE_WIDTH-1];
        if ((head == '0) || (head == '1)) begin
            sat = shifted[dsic_pkg::SAMPLE_WIDTH-1:0];
        end else if (shifted[dsic_pkg::SHIFT_W-1]) begin
            sat = {1'b1, {(dsic_pkg::SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            sat = {1'b0, {(dsic_pkg::SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ctl_in.valid) begin
            residual_reg <= sat;
            last_reg     <= ctl_in.last;
        end
    end

    assign out_valid = valid_reg;
    assign residual  = residual_reg;
    assign last_out  = last_reg;

endmodule

// ----- design/digital_self_interference_canceller_top.sv -----
// Self-interference canceller: each accepted word carries one transmit and one receive
// sample. Once six samples precede the current one, the block returns the receive sample
// from three words back minus the seven-tap filtered transmit window (Q3.12 taps), floored
// by 2^12 and saturated to 16 bits; a last flag marks the final residual and restarts the
// window fill. One word is accepted per clock unless m_ready is low while both stages hold words;
// a residual passes through one registered multiplier per tap and then an adder tree into the
// result register. Taps are written on the configuration channel, which is always ready; the
// user must write them only while no word is in flight, as the block itself does not enforce this.
module digital_self_interference_canceller_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [15:0]        s_tx_sample,
    input  logic signed [15:0]        s_rx_sample,
    input  logic                      s_last_sample,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [15:0]        m_residual,
    output logic                      m_last_out,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  dsic_pkg::cfg_idx_t        cfg_index,
    input  logic signed [15:0]        cfg_data
);

    dsic_pkg::tap_t       taps   [dsic_pkg::TAP_USED];
    dsic_pkg::sample_t    tx_win [dsic_pkg::TAP_USED];
    dsic_pkg::prod_t      prods  [dsic_pkg::TAP_USED];
    dsic_pkg::sample_t    rx_old;
    dsic_pkg::fill_t      fill_count;
    dsic_pkg::stage_ctl_t in_ctl;
    dsic_pkg::stage_ctl_t prod_ctl;
    logic                 full;
    logic                 accept;
    logic                 adv_prod;
    logic                 adv_sum;

    assign cfg_ready = 1'b1;
    assign adv_sum   = !m_valid || m_ready;
    assign adv_prod  = !prod_ctl.valid || adv_sum;
    assign s_ready   = adv_prod;
    assign accept    = s_valid && s_ready;

    assign in_ctl.valid = accept && full;
    assign in_ctl.last  = s_last_sample;
    assign in_ctl.rx    = rx_old;

    dsic_tap_regs u_tap_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .taps      (taps)
    );

    dsic_history u_history (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .tx_sample   (s_tx_sample),
        .rx_sample   (s_rx_sample),
        .last_sample (s_last_sample),
        .tx_win      (tx_win),
        .rx_old      (rx_old),
        .full        (full),
        .fill_count  (fill_count)
    );

    dsic_product_stage u_product_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (adv_prod),
        .ctl_in  (in_ctl),
        .tx_win  (tx_win),
        .taps    (taps),
        .ctl_out (prod_ctl),
        .prods   (prods)
    );

    dsic_sum_stage u_sum_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (adv_sum),
        .ctl_in    (prod_ctl),
        .prods     (prods),
        .out_valid (m_valid),
        .residual  (m_residual),
        .last_out  (m_last_out)
    );

`ifndef ASSERT_OFF
    // a result only appears after passing through the product stage
    a_result_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(prod_ctl.valid))
        else $error("result without a product stage word");

    // a full pipeline with a stalled output must not take a new word
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_ctl.valid && m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline is stalled");

    // a closing word restarts the window fill
    a_last_clears_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_sample) |=> (fill_count == '0))
        else $error("fill count not cleared after last word");
`endif

endmodule
